/* hw/rtl/npcm_pkg.sv */
package npcm_pkg;

	// palette depth and derived widths
	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// fixed field widths
	localparam int CHAN_W        = 8;
	localparam int QCHAN_W       = 4;
	localparam int CODE_W        = 24;
	localparam int MATCH_IDX_W   = 9;
	localparam int NUM_CHAN      = 3;
	localparam int WORD_W        = NUM_CHAN * CHAN_W + CODE_W;
	localparam int SQ_W          = 2 * CHAN_W;
	localparam int DIST_W        = SQ_W + 2;

	// one cell per color channel
	localparam int NCELL         = NUM_CHAN;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [CHAN_W-1:0]   entry_red;
		logic [CHAN_W-1:0]   entry_green;
		logic [CHAN_W-1:0]   entry_blue;
		logic [CODE_W-1:0]   entry_code;
		logic [QCHAN_W-1:0]  query_red;
		logic [QCHAN_W-1:0]  query_green;
		logic [QCHAN_W-1:0]  query_blue;
	} npcm_req_t;

	typedef struct packed {
		logic [CODE_W-1:0]      match_code;
		logic [MATCH_IDX_W-1:0] match_index;
		logic                   found;
		logic                   stored;
	} npcm_rsp_t;

	// token flowing down the cell chain; channel 0 is the one the next cell uses
	typedef struct packed {
		logic [IDX_W-1:0]                idx;
		logic [CODE_W-1:0]               code;
		logic [NUM_CHAN-1:0][CHAN_W-1:0] ent_c;
		logic [NUM_CHAN-1:0][CHAN_W-1:0] ref_c;
		logic [DIST_W-1:0]               distance;
	} npcm_tok_t;

	typedef struct packed {
		logic              found;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
	} npcm_best_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} npcm_state_t;

	// (c*17)^2 / 255, floored
	function automatic logic [CHAN_W-1:0] gamma4(input logic [QCHAN_W-1:0] c);
		logic [CHAN_W-1:0] g;
		case (c)
			4'd0:    g = 8'd0;
			4'd1:    g = 8'd1;
			4'd2:    g = 8'd4;
			4'd3:    g = 8'd10;
			4'd4:    g = 8'd18;
			4'd5:    g = 8'd28;
			4'd6:    g = 8'd40;
			4'd7:    g = 8'd55;
			4'd8:    g = 8'd72;
			4'd9:    g = 8'd91;
			4'd10:   g = 8'd113;
			4'd11:   g = 8'd137;
			4'd12:   g = 8'd163;
			4'd13:   g = 8'd191;
			4'd14:   g = 8'd222;
			4'd15:   g = 8'd255;
			default: g = 8'd0;
		endcase
		return g;
	endfunction

endpackage

/* hw/rtl/npcm_ram.sv */
module npcm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/npcm_cell.sv */
module npcm_cell
	import npcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  npcm_tok_t in_tok,
	output logic      out_valid_s1,
	output npcm_tok_t out_tok_s1
);

	logic [CHAN_W-1:0] diff;
	logic [SQ_W-1:0]   sq;
	npcm_tok_t         nxt;

	// squared difference of channel 0, then rotate so the next cell sees the next channel
	always_comb begin
		diff = (in_tok.ent_c[0] > in_tok.ref_c[0]) ? (in_tok.ent_c[0] - in_tok.ref_c[0])
		                                           : (in_tok.ref_c[0] - in_tok.ent_c[0]);
		sq           = diff * diff;
		nxt          = in_tok;
		nxt.ent_c    = {in_tok.ent_c[0], in_tok.ent_c[2], in_tok.ent_c[1]};
		nxt.ref_c    = {in_tok.ref_c[0], in_tok.ref_c[2], in_tok.ref_c[1]};
		nxt.distance = in_tok.distance + DIST_W'(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_tok_s1 <= nxt;
	end

endmodule

/* hw/rtl/npcm_best.sv */
module npcm_best
	import npcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic       in_valid,
	input  npcm_tok_t  in_tok,
	output npcm_best_t best_q
);

	logic              take;
	logic              found_q;
	logic [DIST_W-1:0] distance_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CODE_W-1:0] code_q;

	// strict compare keeps the lowest index on ties
	assign take = in_valid && (!found_q || (in_tok.distance < distance_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clear) begin
			distance_q <= in_tok.distance;
			idx_q      <= in_tok.idx;
			code_q     <= in_tok.code;
		end
	end

	assign best_q = {found_q, distance_q, idx_q, code_q};

endmodule

/* hw/rtl/nearest_palette_color_match.sv */
// Each request runs ST_SCAN over the N stored entries (1..512), then ST_DRAIN until the
//   pipeline is empty, then ST_DONE; ST_SCAN is skipped when the palette is empty.
// Requests are handled one at a time, the next taken only after the last has left ST_DONE;
//   every load or query sweeps all stored entries through the RAM read port.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low) empties the palette and the pipeline; RAM contents are not cleared.
module nearest_palette_color_match
	import npcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  npcm_req_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output npcm_rsp_t out_data
);

	// sequencer state
	npcm_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;   // stored entries
	logic [CNT_W-1:0] addr_q;    // scan address
	logic             cmd_q;
	logic [NUM_CHAN-1:0][CHAN_W-1:0] ref_q;  // color compared against
	logic [CODE_W-1:0] code_q;

	// sequencer controls
	logic accept;
	logic rd_en;
	logic scan_last;
	logic pipe_busy;
	logic done_fire;
	logic store_ok;

	// RAM
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] wr_word;
	logic              wr_en;

	// pipeline: RAM read stage, then the cell chain
	logic             rd_valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic      chain_valid [NCELL+1];
	npcm_tok_t chain_tok   [NCELL+1];

	npcm_best_t best_q;

	// output register
	logic      out_valid_q;
	npcm_rsp_t out_q;
	npcm_rsp_t rsp_d;

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	assign scan_last = ((addr_q + CNT_W'(1)) == count_q);
	assign pipe_busy = rd_valid_s1 | chain_valid[1] | chain_valid[2] | chain_valid[NCELL];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (count_q == '0) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		done_fire = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_SCAN:  rd_en     = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done_fire = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// load compares against its own color; query against the gamma-expanded color
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= in_data.cmd;
			code_q <= in_data.entry_code;
			if (in_data.cmd == CMD_QUERY) begin
				ref_q <= {gamma4(in_data.query_blue), gamma4(in_data.query_green),
				          gamma4(in_data.query_red)};
			end else begin
				ref_q <= {in_data.entry_blue, in_data.entry_green, in_data.entry_red};
			end
		end
	end

	//------------------------------------------------------------------
	// Palette RAM: {red, green, blue, code}
	//------------------------------------------------------------------
	// a zero distance on a load means the color is already stored
	assign store_ok = (cmd_q == CMD_LOAD)
	                  && !(best_q.found && (best_q.distance == '0))
	                  && (count_q < CNT_W'(TABLE_ENTRIES));
	assign wr_en    = done_fire && store_ok;
	assign wr_word  = {ref_q[0], ref_q[1], ref_q[2], code_q};

	npcm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (addr_q[IDX_W-1:0]),
		.rd_data (rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q[IDX_W-1:0];
	end

	//------------------------------------------------------------------
	// Cell chain: each cell adds one channel's squared difference
	//------------------------------------------------------------------
	always_comb begin
		chain_valid[0]        = rd_valid_s1;
		chain_tok[0].idx      = idx_s1;
		chain_tok[0].code     = rd_word[CODE_W-1:0];
		chain_tok[0].ent_c[0] = rd_word[WORD_W-1 -: CHAN_W];
		chain_tok[0].ent_c[1] = rd_word[WORD_W-1-CHAN_W -: CHAN_W];
		chain_tok[0].ent_c[2] = rd_word[WORD_W-1-2*CHAN_W -: CHAN_W];
		chain_tok[0].ref_c    = ref_q;
		chain_tok[0].distance = '0;
	end

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		npcm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.in_valid     (chain_valid[k]),
			.in_tok       (chain_tok[k]),
			.out_valid_s1 (chain_valid[k+1]),
			.out_tok_s1   (chain_tok[k+1])
		);
	end

	// running minimum, cleared when a new request comes in
	npcm_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.in_valid (chain_valid[NCELL]),
		.in_tok   (chain_tok[NCELL]),
		.best_q   (best_q)
	);

	//------------------------------------------------------------------
	// Result
	//------------------------------------------------------------------
	always_comb begin
		rsp_d = '0;
		if (cmd_q == CMD_QUERY) begin
			if (best_q.found) begin
				rsp_d.match_code  = best_q.code;
				rsp_d.match_index = MATCH_IDX_W'(best_q.idx);
				rsp_d.found       = 1'b1;
			end
		end else if (store_ok) begin
			rsp_d.match_index = MATCH_IDX_W'(count_q[IDX_W-1:0]);
			rsp_d.stored      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (addr_q < count_q))
		else $error("scan read beyond stored entries");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table size");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pipe_busy)
		else $error("request taken while pipeline still busy");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("store did not advance entry count");

	a_rsp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.found && out_q.stored))
		else $error("result flags both found and stored");

endmodule
